// ===== sv/npbe_pkg.sv =====
// Shared widths, types and register codes for the nearest-point-to-box-edges block.
// Used by every module of the block; depends on nothing else.
package npbe_pkg;

    localparam int COORD_BITS  = 13;
    localparam int NUM_CORNERS = 4;
    localparam int CORNER_W    = COORD_BITS + 1;
    // point minus corner and corner minus corner both fit this signed width
    localparam int DIFF_W      = COORD_BITS + 2;
    // twice a coordinate minus the sum of two corners
    localparam int CEN_W       = COORD_BITS + 3;
    localparam int MUL_W       = 2 * DIFF_W;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DEN_W       = 2 * COORD_BITS + 3;
    localparam int NUM_W       = 2 * DEN_W;
    localparam int ACC_W       = NUM_W + DEN_W + 1;
    localparam int CDIST_W     = 2 * CEN_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [NUM_W-1:0] BOUND_SQ = NUM_W'(64'd10000 * 64'd10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C0X = 3'd0,
        REG_C0Y = 3'd1,
        REG_C1X = 3'd2,
        REG_C1Y = 3'd3,
        REG_C2X = 3'd4,
        REG_C2Y = 3'd5,
        REG_C3X = 3'd6,
        REG_C3Y = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_CORNERS-1:0][CORNER_W-1:0] x;
        logic [NUM_CORNERS-1:0][CORNER_W-1:0] y;
    } t_corners;

    typedef struct packed {
        logic [COORD_BITS-1:0]              px;
        logic [COORD_BITS-1:0]              py;
        logic                               last;
        logic [NUM_CORNERS-1:0][DIFF_W-1:0] dx;
        logic [NUM_CORNERS-1:0][DIFF_W-1:0] dy;
    } t_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L01A, ST_L01B, ST_L03A, ST_L03B,
        ST_VV0, ST_VV1, ST_T0, ST_T1, ST_CR0, ST_CR1,
        ST_Q0, ST_Q1, ST_R0, ST_R1, ST_CRSQ, ST_PICK,
        ST_CL0, ST_CL1, ST_CRR0, ST_CRR1, ST_CMP,
        ST_DA0, ST_DA1, ST_DB0, ST_DB1, ST_EMIT
    } t_step;

endpackage

// ===== sv/npbe_front.sv =====
// Front end: takes input transfers and turns each point into its offsets from the four corners.
// Depends on npbe_pkg; feeds npbe_queue.
module npbe_front import npbe_pkg::*; (
    input  logic                  i_valid,
    input  logic                  i_queue_full,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic                  i_last_point,
    input  t_corners              i_corners,
    output logic                  o_stall,
    output logic                  o_push,
    output t_item                 o_item
);

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_item.px   = i_point_x;
        o_item.py   = i_point_y;
        o_item.last = i_last_point;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            // Modular subtraction gives the exact two's complement offset.
            o_item.dx[k] = {2'b00, i_point_x}
                         - {i_corners.x[k][CORNER_W-1], i_corners.x[k]};
            o_item.dy[k] = {2'b00, i_point_y}
                         - {i_corners.y[k][CORNER_W-1], i_corners.y[k]};
        end
    end

endmodule

// ===== sv/npbe_queue.sv =====
// Short queue of points with corner offsets between the front end and distance sequencer.
// Depends on npbe_pkg.
module npbe_queue import npbe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== sv/npbe_back.sv =====
// Distance sequencer: one shared multiplier steps through the edge choice, both segment
// distances, the running-minimum compare and the centre test. Depends on npbe_pkg.
module npbe_back import npbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_corners              i_corners,
    input  t_item                 i_item,
    input  logic                  i_item_valid,
    output logic                  o_pop,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [COORD_BITS-1:0] o_chosen_x,
    output logic [COORD_BITS-1:0] o_chosen_y,
    output logic                  o_chosen_edge,
    output logic                  o_found
);

    function automatic logic signed [MUL_W-1:0] ext_diff(input logic [DIFF_W-1:0] v);
        return {{(MUL_W-DIFF_W){v[DIFF_W-1]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] ext_cen(input logic [CEN_W-1:0] v);
        return {{(MUL_W-CEN_W){v[CEN_W-1]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] ext_uns(input logic [DEN_W-1:0] v);
        return {{(MUL_W-DEN_W){1'b0}}, v};
    endfunction

    function automatic logic [DIFF_W-1:0] csub(input logic [CORNER_W-1:0] a,
                                               input logic [CORNER_W-1:0] b);
        return {a[CORNER_W-1], a} - {b[CORNER_W-1], b};
    endfunction

    function automatic logic [CEN_W-1:0] cen_off(input logic [COORD_BITS-1:0] p,
                                                 input logic [CEN_W-1:0]      s);
        return {{(CEN_W-COORD_BITS-1){1'b0}}, p, 1'b0} - s;
    endfunction

    t_step r_step, n_step;

    logic                    r_edge, n_edge;
    logic                    r_side01, n_side01;
    logic [DEN_W-1:0]        r_l01, n_l01;
    logic [DEN_W-1:0]        r_l03, n_l03;
    logic [DEN_W-1:0]        r_vv, n_vv;
    logic [MUL_W-1:0]        r_t, n_t;
    logic [MUL_W-1:0]        r_cr, n_cr;
    logic [DEN_W-1:0]        r_q, n_q;
    logic [DEN_W-1:0]        r_r, n_r;
    logic [NUM_W-1:0]        r_crsq, n_crsq;
    logic [NUM_W-1:0]        r_num, n_num;
    logic [DEN_W-1:0]        r_den, n_den;
    logic [ACC_W-1:0]        r_accl, n_accl;
    logic [ACC_W-1:0]        r_accr, n_accr;
    logic [CDIST_W-1:0]      r_da, n_da;
    logic [CDIST_W-1:0]      r_db, n_db;

    logic [NUM_W-1:0]        r_bnum_a, n_bnum_a, r_bnum_b, n_bnum_b;
    logic [DEN_W-1:0]        r_bden_a, n_bden_a, r_bden_b, n_bden_b;
    logic [COORD_BITS-1:0]   r_bx_a, n_bx_a, r_by_a, n_by_a;
    logic [COORD_BITS-1:0]   r_bx_b, n_bx_b, r_by_b, n_by_b;
    logic                    r_found_a, n_found_a, r_found_b, n_found_b;

    logic                    r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]   r_out_x, n_out_x, r_out_y, n_out_y;
    logic                    r_out_edge, n_out_edge;
    logic                    r_out_found, n_out_found;

    logic signed [MUL_W-1:0]  ma, mb;
    logic signed [PROD_W-1:0] prod;

    logic                    end_c1;
    logic [CORNER_W-1:0]     scx, scy, ecx, ecy;
    logic [DIFF_W-1:0]       vx, vy, wx, wy, ux, uy;
    logic [DIFF_W-1:0]       e01x, e01y, e03x, e03y;
    logic [NUM_W-1:0]        bnum;
    logic [DEN_W-1:0]        bden;
    logic [CEN_W-1:0]        sx2, sy2;
    logic [DEN_W-1:0]        l03_sum;
    logic [ACC_W-1:0]        prod_acc;

    // Edge A runs from corner 0, edge B from corner 2; the far end is corner 1 or 3.
    assign end_c1 = (r_edge != r_side01);
    assign scx    = r_edge ? i_corners.x[2] : i_corners.x[0];
    assign scy    = r_edge ? i_corners.y[2] : i_corners.y[0];
    assign ecx    = end_c1 ? i_corners.x[1] : i_corners.x[3];
    assign ecy    = end_c1 ? i_corners.y[1] : i_corners.y[3];
    assign vx     = csub(ecx, scx);
    assign vy     = csub(ecy, scy);
    assign wx     = r_edge ? i_item.dx[2] : i_item.dx[0];
    assign wy     = r_edge ? i_item.dy[2] : i_item.dy[0];
    assign ux     = end_c1 ? i_item.dx[1] : i_item.dx[3];
    assign uy     = end_c1 ? i_item.dy[1] : i_item.dy[3];
    assign e01x   = csub(i_corners.x[0], i_corners.x[1]);
    assign e01y   = csub(i_corners.y[0], i_corners.y[1]);
    assign e03x   = csub(i_corners.x[0], i_corners.x[3]);
    assign e03y   = csub(i_corners.y[0], i_corners.y[3]);
    assign bnum   = r_edge ? r_bnum_b : r_bnum_a;
    assign bden   = r_edge ? r_bden_b : r_bden_a;
    assign sx2    = {{(CEN_W-CORNER_W){i_corners.x[0][CORNER_W-1]}}, i_corners.x[0]}
                  + {{(CEN_W-CORNER_W){i_corners.x[2][CORNER_W-1]}}, i_corners.x[2]};
    assign sy2    = {{(CEN_W-CORNER_W){i_corners.y[0][CORNER_W-1]}}, i_corners.y[0]}
                  + {{(CEN_W-CORNER_W){i_corners.y[2][CORNER_W-1]}}, i_corners.y[2]};

    assign prod     = ma * mb;
    assign l03_sum  = r_l03 + prod[DEN_W-1:0];
    assign prod_acc = {{(ACC_W-NUM_W){1'b0}}, prod[NUM_W-1:0]};

    assign o_out_valid   = r_out_valid;
    assign o_chosen_x    = r_out_x;
    assign o_chosen_y    = r_out_y;
    assign o_chosen_edge = r_out_edge;
    assign o_found       = r_out_found;

    always_comb begin
        n_step      = r_step;
        n_edge      = r_edge;
        n_side01    = r_side01;
        n_l01       = r_l01;
        n_l03       = r_l03;
        n_vv        = r_vv;
        n_t         = r_t;
        n_cr        = r_cr;
        n_q         = r_q;
        n_r         = r_r;
        n_crsq      = r_crsq;
        n_num       = r_num;
        n_den       = r_den;
        n_accl      = r_accl;
        n_accr      = r_accr;
        n_da        = r_da;
        n_db        = r_db;
        n_bnum_a    = r_bnum_a;
        n_bnum_b    = r_bnum_b;
        n_bden_a    = r_bden_a;
        n_bden_b    = r_bden_b;
        n_bx_a      = r_bx_a;
        n_by_a      = r_by_a;
        n_bx_b      = r_bx_b;
        n_by_b      = r_by_b;
        n_found_a   = r_found_a;
        n_found_b   = r_found_b;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_edge  = r_out_edge;
        n_out_found = r_out_found;
        o_pop       = 1'b0;
        ma          = '0;
        mb          = '0;

        case (r_step)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_step = ST_L01A;
                end
            end
            ST_L01A: begin
                ma     = ext_diff(e01x);
                mb     = ext_diff(e01x);
                n_l01  = prod[DEN_W-1:0];
                n_step = ST_L01B;
            end
            ST_L01B: begin
                ma     = ext_diff(e01y);
                mb     = ext_diff(e01y);
                n_l01  = r_l01 + prod[DEN_W-1:0];
                n_step = ST_L03A;
            end
            ST_L03A: begin
                ma     = ext_diff(e03x);
                mb     = ext_diff(e03x);
                n_l03  = prod[DEN_W-1:0];
                n_step = ST_L03B;
            end
            ST_L03B: begin
                ma       = ext_diff(e03y);
                mb       = ext_diff(e03y);
                n_side01 = (r_l01 > l03_sum);
                n_edge   = 1'b0;
                n_step   = ST_VV0;
            end
            ST_VV0: begin
                ma     = ext_diff(vx);
                mb     = ext_diff(vx);
                n_vv   = prod[DEN_W-1:0];
                n_step = ST_VV1;
            end
            ST_VV1: begin
                ma     = ext_diff(vy);
                mb     = ext_diff(vy);
                n_vv   = r_vv + prod[DEN_W-1:0];
                n_step = ST_T0;
            end
            ST_T0: begin
                ma     = ext_diff(wx);
                mb     = ext_diff(vx);
                n_t    = prod[MUL_W-1:0];
                n_step = ST_T1;
            end
            ST_T1: begin
                ma     = ext_diff(wy);
                mb     = ext_diff(vy);
                n_t    = r_t + prod[MUL_W-1:0];
                n_step = ST_CR0;
            end
            ST_CR0: begin
                ma     = ext_diff(wx);
                mb     = ext_diff(vy);
                n_cr   = prod[MUL_W-1:0];
                n_step = ST_CR1;
            end
            ST_CR1: begin
                ma     = ext_diff(wy);
                mb     = ext_diff(vx);
                n_cr   = r_cr - prod[MUL_W-1:0];
                n_step = ST_Q0;
            end
            ST_Q0: begin
                ma     = ext_diff(wx);
                mb     = ext_diff(wx);
                n_q    = prod[DEN_W-1:0];
                n_step = ST_Q1;
            end
            ST_Q1: begin
                ma     = ext_diff(wy);
                mb     = ext_diff(wy);
                n_q    = r_q + prod[DEN_W-1:0];
                n_step = ST_R0;
            end
            ST_R0: begin
                ma     = ext_diff(ux);
                mb     = ext_diff(ux);
                n_r    = prod[DEN_W-1:0];
                n_step = ST_R1;
            end
            ST_R1: begin
                ma     = ext_diff(uy);
                mb     = ext_diff(uy);
                n_r    = r_r + prod[DEN_W-1:0];
                n_step = ST_CRSQ;
            end
            ST_CRSQ: begin
                ma     = $signed(r_cr);
                mb     = $signed(r_cr);
                n_crsq = prod[NUM_W-1:0];
                n_step = ST_PICK;
            end
            ST_PICK: begin
                // A zero-length edge and a projection before the start both measure to the
                // start corner; one past the end measures to the end corner.
                if (r_vv == '0 || r_t[MUL_W-1]) begin
                    n_num = {{(NUM_W-DEN_W){1'b0}}, r_q};
                    n_den = DEN_W'(1);
                end else if ($signed(r_t) > $signed({1'b0, r_vv})) begin
                    n_num = {{(NUM_W-DEN_W){1'b0}}, r_r};
                    n_den = DEN_W'(1);
                end else begin
                    n_num = r_crsq;
                    n_den = r_vv;
                end
                n_step = ST_CL0;
            end
            ST_CL0: begin
                ma     = ext_uns(r_num[DEN_W-1:0]);
                mb     = ext_uns(bden);
                n_accl = prod_acc;
                n_step = ST_CL1;
            end
            ST_CL1: begin
                ma     = ext_uns(r_num[NUM_W-1:DEN_W]);
                mb     = ext_uns(bden);
                n_accl = r_accl + (prod_acc << DEN_W);
                n_step = ST_CRR0;
            end
            ST_CRR0: begin
                ma     = ext_uns(bnum[DEN_W-1:0]);
                mb     = ext_uns(r_den);
                n_accr = prod_acc;
                n_step = ST_CRR1;
            end
            ST_CRR1: begin
                ma     = ext_uns(bnum[NUM_W-1:DEN_W]);
                mb     = ext_uns(r_den);
                n_accr = r_accr + (prod_acc << DEN_W);
                n_step = ST_CMP;
            end
            ST_CMP: begin
                if (r_accl < r_accr) begin
                    if (r_edge) begin
                        n_bnum_b  = r_num;
                        n_bden_b  = r_den;
                        n_bx_b    = i_item.px;
                        n_by_b    = i_item.py;
                        n_found_b = 1'b1;
                    end else begin
                        n_bnum_a  = r_num;
                        n_bden_a  = r_den;
                        n_bx_a    = i_item.px;
                        n_by_a    = i_item.py;
                        n_found_a = 1'b1;
                    end
                end
                if (!r_edge) begin
                    n_edge = 1'b1;
                    n_step = ST_VV0;
                end else if (i_item.last) begin
                    n_step = ST_DA0;
                end else begin
                    o_pop  = 1'b1;
                    n_step = ST_IDLE;
                end
            end
            ST_DA0: begin
                ma     = ext_cen(cen_off(r_bx_a, sx2));
                mb     = ext_cen(cen_off(r_bx_a, sx2));
                n_da   = prod[CDIST_W-1:0];
                n_step = ST_DA1;
            end
            ST_DA1: begin
                ma     = ext_cen(cen_off(r_by_a, sy2));
                mb     = ext_cen(cen_off(r_by_a, sy2));
                n_da   = r_da + prod[CDIST_W-1:0];
                n_step = ST_DB0;
            end
            ST_DB0: begin
                ma     = ext_cen(cen_off(r_bx_b, sx2));
                mb     = ext_cen(cen_off(r_bx_b, sx2));
                n_db   = prod[CDIST_W-1:0];
                n_step = ST_DB1;
            end
            ST_DB1: begin
                ma     = ext_cen(cen_off(r_by_b, sy2));
                mb     = ext_cen(cen_off(r_by_b, sy2));
                n_db   = r_db + prod[CDIST_W-1:0];
                n_step = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    // Edge B wins a tie.
                    if (r_da < r_db) begin
                        n_out_x     = r_bx_a;
                        n_out_y     = r_by_a;
                        n_out_edge  = 1'b0;
                        n_out_found = r_found_a;
                    end else begin
                        n_out_x     = r_bx_b;
                        n_out_y     = r_by_b;
                        n_out_edge  = 1'b1;
                        n_out_found = r_found_b;
                    end
                    n_out_valid = 1'b1;
                    n_bnum_a    = BOUND_SQ;
                    n_bnum_b    = BOUND_SQ;
                    n_bden_a    = DEN_W'(1);
                    n_bden_b    = DEN_W'(1);
                    n_bx_a      = '0;
                    n_by_a      = '0;
                    n_bx_b      = '0;
                    n_by_b      = '0;
                    n_found_a   = 1'b0;
                    n_found_b   = 1'b0;
                    o_pop       = 1'b1;
                    n_step      = ST_IDLE;
                end
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bnum_a    <= BOUND_SQ;
            r_bnum_b    <= BOUND_SQ;
            r_bden_a    <= DEN_W'(1);
            r_bden_b    <= DEN_W'(1);
            r_bx_a      <= '0;
            r_by_a      <= '0;
            r_bx_b      <= '0;
            r_by_b      <= '0;
            r_found_a   <= 1'b0;
            r_found_b   <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_bnum_a    <= n_bnum_a;
            r_bnum_b    <= n_bnum_b;
            r_bden_a    <= n_bden_a;
            r_bden_b    <= n_bden_b;
            r_bx_a      <= n_bx_a;
            r_by_a      <= n_by_a;
            r_bx_b      <= n_bx_b;
            r_by_b      <= n_by_b;
            r_found_a   <= n_found_a;
            r_found_b   <= n_found_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge      <= n_edge;
        r_side01    <= n_side01;
        r_l01       <= n_l01;
        r_l03       <= n_l03;
        r_vv        <= n_vv;
        r_t         <= n_t;
        r_cr        <= n_cr;
        r_q         <= n_q;
        r_r         <= n_r;
        r_crsq      <= n_crsq;
        r_num       <= n_num;
        r_den       <= n_den;
        r_accl      <= n_accl;
        r_accr      <= n_accr;
        r_da        <= n_da;
        r_db        <= n_db;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_edge  <= n_out_edge;
        r_out_found <= n_out_found;
    end

endmodule

// ===== sv/nearest_point_to_box_edges.sv =====
// Top level of the nearest-point-to-box-edges block: corner registers, front end, queue and
// distance sequencer. Depends on npbe_pkg, npbe_front, npbe_queue and npbe_back.
//
// Contour points arrive one per input transfer; the point flagged as last closes the region
// and produces one result transfer naming the kept point nearer the rectangle centre. All
// multiplication goes through a single shared multiplier in the back-end sequencer, which takes
// each point through its steps in turn; the last point of a region also waits for the output
// register to empty. The point being worked on keeps its entry in the two-entry queue
// until it is finished, so the front end can take one further point while the sequencer is
// busy, and a finished result sits in its own register so work continues while it waits to
// be taken. Corner registers are written through the plain write port and should only
// change while no point is in flight.
module nearest_point_to_box_edges import npbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CORNER_W-1:0]   i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic                  i_last_point,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_chosen_x,
    output logic [COORD_BITS-1:0] o_chosen_y,
    output logic                  o_chosen_edge,
    output logic                  o_found
);

    t_corners r_corners;
    t_item    front_item;
    t_item    head_item;
    logic     push;
    logic     pop;
    logic     queue_full;
    logic     queue_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corners <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_C0X: r_corners.x[0] <= i_cfg_data;
                REG_C0Y: r_corners.y[0] <= i_cfg_data;
                REG_C1X: r_corners.x[1] <= i_cfg_data;
                REG_C1Y: r_corners.y[1] <= i_cfg_data;
                REG_C2X: r_corners.x[2] <= i_cfg_data;
                REG_C2Y: r_corners.y[2] <= i_cfg_data;
                REG_C3X: r_corners.x[3] <= i_cfg_data;
                REG_C3Y: r_corners.y[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    npbe_front u_front (
        .i_valid      (i_valid),
        .i_queue_full (queue_full),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .i_corners    (r_corners),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_item       (front_item)
    );

    npbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head_item)
    );

    npbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_corners     (r_corners),
        .i_item        (head_item),
        .i_item_valid  (!queue_empty),
        .o_pop         (pop),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_chosen_x    (o_chosen_x),
        .o_chosen_y    (o_chosen_y),
        .o_chosen_edge (o_chosen_edge),
        .o_found       (o_found)
    );

endmodule

// ===== tb/sv/npbe_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for nearest_point_to_box_edges: follows corner writes and point transfers, predicts
// the chosen point of every region and checks each result transfer against it.
// Depends on npbe_pkg only.
module npbe_checker import npbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CORNER_W-1:0]   i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic                  i_last_point,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [COORD_BITS-1:0] i_chosen_x,
    input  logic [COORD_BITS-1:0] i_chosen_y,
    input  logic                  i_chosen_edge,
    input  logic                  i_found,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    localparam logic            EDGE_A      = 1'b0;
    localparam logic            EDGE_B      = 1'b1;
    localparam longint unsigned START_BOUND = 64'd10000 * 64'd10000;

    // Best point so far for one long edge; the squared distance is num / den.
    typedef struct {
        longint unsigned       num;
        longint unsigned       den;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  found;
    } t_nearest;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  side;
        logic                  found;
    } t_choice;

    logic signed [CORNER_W-1:0] box_x [NUM_CORNERS];
    logic signed [CORNER_W-1:0] box_y [NUM_CORNERS];
    t_nearest                   nearest [2];
    t_choice                    expected_choices [$];
    int                         mismatches = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    function automatic longint sq_len(input longint dx, input longint dy);
        return dx * dx + dy * dy;
    endfunction

    function automatic longint centre_dist(input logic [COORD_BITS-1:0] x,
                                           input logic [COORD_BITS-1:0] y,
                                           input longint sum_x, input longint sum_y);
        return sq_len(2 * longint'(x) - sum_x, 2 * longint'(y) - sum_y);
    endfunction

    function automatic void clear_nearest();
        foreach (nearest[s]) begin
            nearest[s].num   = START_BOUND;
            nearest[s].den   = 1;
            nearest[s].x     = '0;
            nearest[s].y     = '0;
            nearest[s].found = 1'b0;
        end
    endfunction

    // Distance from the point to segment a-b, clamped at both ends, compared exactly
    // against the kept one by cross multiplication.
    function automatic void offer_point(input logic side, input longint ax, ay, bx, by,
                                        input logic [COORD_BITS-1:0] x, y);
        longint          vx, vy, wx, wy, vv, proj, cr, px, py;
        longint unsigned num, den;
        logic [127:0]    lhs, rhs;
        px  = longint'(x);
        py  = longint'(y);
        vx  = bx - ax;
        vy  = by - ay;
        wx  = px - ax;
        wy  = py - ay;
        vv  = sq_len(vx, vy);
        den = 1;
        if (vv == 0) begin
            num = sq_len(wx, wy);
        end else begin
            proj = wx * vx + wy * vy;
            if (proj < 0) begin
                num = sq_len(wx, wy);
            end else if (proj > vv) begin
                num = sq_len(px - bx, py - by);
            end else begin
                cr  = wx * vy - wy * vx;
                num = cr * cr;
                den = vv;
            end
        end
        lhs = num;
        lhs = lhs * nearest[side].den;
        rhs = nearest[side].num;
        rhs = rhs * den;
        if (lhs < rhs) begin
            nearest[side].num   = num;
            nearest[side].den   = den;
            nearest[side].x     = x;
            nearest[side].y     = y;
            nearest[side].found = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        longint  cx [NUM_CORNERS];
        longint  cy [NUM_CORNERS];
        longint  da, db;
        logic    pick;
        t_choice want;
        string   diff;
        if (!i_rst_n) begin
            foreach (box_x[k]) begin
                box_x[k] = '0;
                box_y[k] = '0;
            end
            clear_nearest();
            expected_choices.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_C0X: box_x[0] = i_cfg_data;
                    REG_C0Y: box_y[0] = i_cfg_data;
                    REG_C1X: box_x[1] = i_cfg_data;
                    REG_C1Y: box_y[1] = i_cfg_data;
                    REG_C2X: box_x[2] = i_cfg_data;
                    REG_C2Y: box_y[2] = i_cfg_data;
                    REG_C3X: box_x[3] = i_cfg_data;
                    REG_C3Y: box_y[3] = i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                foreach (cx[k]) begin
                    cx[k] = box_x[k];
                    cy[k] = box_y[k];
                end
                // Side 0-1 must be strictly longer to be taken as the first long edge.
                if (sq_len(cx[0] - cx[1], cy[0] - cy[1]) > sq_len(cx[0] - cx[3], cy[0] - cy[3]))
                begin
                    offer_point(EDGE_A, cx[0], cy[0], cx[1], cy[1], i_point_x, i_point_y);
                    offer_point(EDGE_B, cx[2], cy[2], cx[3], cy[3], i_point_x, i_point_y);
                end else begin
                    offer_point(EDGE_A, cx[0], cy[0], cx[3], cy[3], i_point_x, i_point_y);
                    offer_point(EDGE_B, cx[2], cy[2], cx[1], cy[1], i_point_x, i_point_y);
                end
                if (i_last_point) begin
                    da = centre_dist(nearest[EDGE_A].x, nearest[EDGE_A].y,
                                     cx[0] + cx[2], cy[0] + cy[2]);
                    db = centre_dist(nearest[EDGE_B].x, nearest[EDGE_B].y,
                                     cx[0] + cx[2], cy[0] + cy[2]);
                    // Edge B wins a tie.
                    pick       = (da < db) ? EDGE_A : EDGE_B;
                    want.x     = nearest[pick].x;
                    want.y     = nearest[pick].y;
                    want.side  = pick;
                    want.found = nearest[pick].found;
                    expected_choices.insert(expected_choices.size(), want);
                    clear_nearest();
                end
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_choices.size() == 0) begin
                    report_mismatch($sformatf("result (%0d,%0d) with none outstanding",
                                              i_chosen_x, i_chosen_y));
                end else begin
                    want = expected_choices.pop_front();
                    diff = "";
                    if (i_chosen_x !== want.x)
                        diff = {diff, $sformatf(" x %0d/%0d", i_chosen_x, want.x)};
                    if (i_chosen_y !== want.y)
                        diff = {diff, $sformatf(" y %0d/%0d", i_chosen_y, want.y)};
                    if (i_chosen_edge !== want.side)
                        diff = {diff, $sformatf(" edge %b/%b", i_chosen_edge, want.side)};
                    if (i_found !== want.found)
                        diff = {diff, $sformatf(" found %b/%b", i_found, want.found)};
                    if (diff != "")
                        report_mismatch({"result field got/wanted:", diff});
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_choices.size();
    end

endmodule

// ===== tb/sv/tb_nearest_point_to_box_edges.sv =====
`timescale 1ns / 100ps
// Regression top for nearest_point_to_box_edges: clock, reset, corner writes, contour point
// stimulus, result-side stalls and the verdict. Depends on npbe_pkg, the block and npbe_checker.
module tb_nearest_point_to_box_edges;
    import npbe_pkg::*;

    localparam int IDLE_PCT      = 23;
    localparam int SETTLE_CYCLES = 250;
    localparam int RANDOM_POINTS = 500;
    localparam int HOLD_AFTER    = 25;   // results taken before the long receiver hold-off
    localparam int HOLD_CYCLES   = 600;
    localparam int CALM_FIRST    = 150;  // random points sent back to back
    localparam int CALM_LAST     = 260;
    localparam int RX_CALM_FIRST = 40;   // results taken without any stall
    localparam int RX_CALM_LAST  = 55;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int CORNER_MIN    = -(1 << COORD_BITS);
    localparam int CORNER_MAX    = (1 << COORD_BITS) - 1;

    typedef enum int {BOX_RECT, BOX_RANDOM, BOX_EXTREME, BOX_DEGENERATE} t_box_kind;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CORNER_W-1:0]   i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic [COORD_BITS-1:0] i_point_x    = '0;
    logic [COORD_BITS-1:0] i_point_y    = '0;
    logic                  i_last_point = 1'b0;
    logic                  i_stall      = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [COORD_BITS-1:0] o_chosen_x;
    logic [COORD_BITS-1:0] o_chosen_y;
    logic                  o_chosen_edge;
    logic                  o_found;
    int                    mismatch_count;
    int                    results_pending;
    bit                    sender_calm = 1'b0;
    int                    box_x [NUM_CORNERS];
    int                    box_y [NUM_CORNERS];

    nearest_point_to_box_edges i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_chosen_x   (o_chosen_x),
        .o_chosen_y   (o_chosen_y),
        .o_chosen_edge(o_chosen_edge),
        .o_found      (o_found)
    );

    npbe_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_chosen_x   (o_chosen_x),
        .i_chosen_y   (o_chosen_y),
        .i_chosen_edge(o_chosen_edge),
        .i_found      (o_found),
        .o_mismatches (mismatch_count),
        .o_outstanding(results_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int any_corner();
        return int'($urandom_range(CORNER_MAX - CORNER_MIN)) + CORNER_MIN;
    endfunction

    function automatic int extreme_corner();
        case ($urandom_range(2))
            0:       return CORNER_MIN;
            1:       return 0;
            default: return CORNER_MAX;
        endcase
    endfunction

    function automatic void pick_box();
        t_box_kind kind;
        int        ux, uy, r;
        kind = t_box_kind'($urandom_range(3));
        case (kind)
            BOX_RECT: begin
                // Side u from corner 0, the other side perpendicular and scaled by r/8.
                box_x[0] = $urandom_range(COORD_MAX);
                box_y[0] = $urandom_range(COORD_MAX);
                ux       = int'($urandom_range(6000)) - 3000;
                uy       = int'($urandom_range(6000)) - 3000;
                r        = $urandom_range(1, 16);
                box_x[1] = box_x[0] + ux;
                box_y[1] = box_y[0] + uy;
                box_x[3] = box_x[0] - uy * r / 8;
                box_y[3] = box_y[0] + ux * r / 8;
                box_x[2] = box_x[1] + box_x[3] - box_x[0];
                box_y[2] = box_y[1] + box_y[3] - box_y[0];
                foreach (box_x[k]) begin
                    box_x[k] = clamp(box_x[k], CORNER_MIN, CORNER_MAX);
                    box_y[k] = clamp(box_y[k], CORNER_MIN, CORNER_MAX);
                end
            end
            BOX_RANDOM: begin
                foreach (box_x[k]) begin
                    box_x[k] = any_corner();
                    box_y[k] = any_corner();
                end
            end
            BOX_EXTREME: begin
                foreach (box_x[k]) begin
                    box_x[k] = extreme_corner();
                    box_y[k] = extreme_corner();
                end
            end
            default: begin
                // Zero-length segments: corner 1 on corner 0, corner 3 on corner 2.
                box_x[0] = any_corner();
                box_y[0] = any_corner();
                box_x[2] = $urandom_range(1) ? any_corner() : box_x[0];
                box_y[2] = $urandom_range(1) ? any_corner() : box_y[0];
                box_x[1] = box_x[0];
                box_y[1] = box_y[0];
                box_x[3] = box_x[2];
                box_y[3] = box_y[2];
            end
        endcase
    endfunction

    // Mostly points close to a side of the box, so that the running minimum moves often.
    function automatic void next_point(inout int x, inout int y);
        int roll, i, j, t;
        roll = $urandom_range(99);
        if (roll < 70) begin
            i = $urandom_range(NUM_CORNERS - 1);
            j = (i + 1) % NUM_CORNERS;
            t = $urandom_range(256);
            x = clamp(box_x[i] + (box_x[j] - box_x[i]) * t / 256 + int'($urandom_range(60)) - 30,
                      0, COORD_MAX);
            y = clamp(box_y[i] + (box_y[j] - box_y[i]) * t / 256 + int'($urandom_range(60)) - 30,
                      0, COORD_MAX);
        end else if (roll < 85) begin
            x = $urandom_range(COORD_MAX);
            y = $urandom_range(COORD_MAX);
        end else if (roll < 95) begin
            x = $urandom_range(1) ? COORD_MAX : 0;
            y = $urandom_range(1) ? COORD_MAX : 0;
        end
        // Otherwise the previous point repeats, giving equal distances.
    endfunction

    task automatic write_reg(input t_reg_idx idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CORNER_W'(value);
        @(posedge i_clk);
    endtask

    task automatic load_box();
        write_reg(REG_C0X, box_x[0]);
        write_reg(REG_C0Y, box_y[0]);
        write_reg(REG_C1X, box_x[1]);
        write_reg(REG_C1Y, box_y[1]);
        write_reg(REG_C2X, box_x[2]);
        write_reg(REG_C2Y, box_y[2]);
        write_reg(REG_C3X, box_x[3]);
        write_reg(REG_C3Y, box_y[3]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_point(input int x, input int y, input bit last);
        while (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_point_x    <= COORD_BITS'(x);
        i_point_y    <= COORD_BITS'(y);
        i_last_point <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Wait for every outstanding result, then long enough for trailing points to be processed.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : receiver
        int  taken;
        int  hold_left;
        bit  held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                taken++;
            if (!held && taken == HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (taken >= RX_CALM_FIRST && taken < RX_CALM_LAST) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin : stimulus
        int n, sent, phase_len, region_left, px, py;
        bit leave_open;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corners at their reset value: both edges shrink to a single point at the origin.
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(5, 3, 1'b0);
        send_point(0, 0, 1'b1);
        settle();

        // Wide axis-aligned box: side 0-1 is the longer one.
        box_x = '{100, 4100, 4100, 100};
        box_y = '{100, 100, 2100, 2100};
        load_box();
        send_point(2000, 50, 1'b0);
        send_point(1000, 150, 1'b0);     // same distance to the first edge, not taken
        send_point(50, 80, 1'b0);        // before the start of the first edge
        send_point(5000, 2200, 1'b0);    // beyond the end of the first edge
        send_point(3000, 101, 1'b1);
        // This region stays open while the corners change.
        send_point(2000, 2099, 1'b0);
        send_point(COORD_MAX, 0, 1'b0);
        settle();

        // All corners at the negative extreme: nothing comes within the bound.
        box_x = '{CORNER_MIN, CORNER_MIN, CORNER_MIN, CORNER_MIN};
        box_y = '{CORNER_MIN, CORNER_MIN, CORNER_MIN, CORNER_MIN};
        load_box();
        send_point(0, 0, 1'b1);
        send_point(0, COORD_MAX, 1'b0);
        send_point(0, 0, 1'b1);
        settle();

        box_x = '{CORNER_MAX, CORNER_MAX, CORNER_MAX, CORNER_MAX};
        box_y = '{CORNER_MAX, CORNER_MAX, CORNER_MAX, CORNER_MAX};
        load_box();
        send_point(0, 0, 1'b0);
        send_point(0, 0, 1'b1);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        settle();

        // Side 0-3 longer; the first pair sits level with the centre, the second does not.
        box_x = '{0, 0, COORD_MAX, COORD_MAX};
        box_y = '{0, 1000, 1000, 0};
        load_box();
        send_point(4000, 10, 1'b0);
        send_point(4000, 990, 1'b1);
        send_point(4000, 100, 1'b0);
        send_point(4000, 990, 1'b1);
        settle();

        // Square spanning the full corner range: equal sides.
        box_x = '{CORNER_MIN, CORNER_MAX, CORNER_MAX, CORNER_MIN};
        box_y = '{CORNER_MIN, CORNER_MIN, CORNER_MAX, CORNER_MAX};
        load_box();
        send_point(0, 0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        settle();

        sent        = 0;
        region_left = 0;
        px          = 0;
        py          = 0;
        while (sent < RANDOM_POINTS) begin
            pick_box();
            load_box();
            phase_len  = $urandom_range(40, 80);
            leave_open = ($urandom_range(3) == 0);
            n          = 0;
            while (n < phase_len || (!leave_open && region_left != 0)) begin
                if (region_left == 0)
                    region_left = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12);
                next_point(px, py);
                region_left--;
                sender_calm = (sent >= CALM_FIRST && sent < CALM_LAST);
                send_point(px, py, region_left == 0);
                n++;
                sent++;
            end
            sender_calm = 1'b0;
            settle();
        end

        if (mismatch_count == 0) begin
            $display("nearest_point_to_box_edges regression: pass");
        end else begin
            $display("nearest_point_to_box_edges regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("nearest_point_to_box_edges regression: fail");
        $finish;
    end

endmodule
